>>> rtl/core/assert_macros.svh
// Assertion macros used by the top-level RTL file of the undistortion block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
// Clocked check, disabled during reset.
`define PUIU_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);
// Clocked check that also holds during reset.
`define PUIU_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define PUIU_ASSERT(lbl, prop, msg)
`define PUIU_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

>>> rtl/core/puiu_pkg.sv
// Package: widths, register indexes, pipeline payload types and fixed-point helpers.
`timescale 1ns / 1ps
package puiu_pkg;
	localparam int QW         = 24;
	localparam int PIXW       = 16;
	localparam int IFW        = 24;
	localparam int CFG_IDX_W  = 8;
	localparam int CFG_DATA_W = 24;
	localparam int ITERATIONS = 8;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_CENTER_X      = 8'd0,
		REG_CENTER_Y      = 8'd1,
		REG_INV_FOCAL_X   = 8'd2,
		REG_INV_FOCAL_Y   = 8'd3,
		REG_RADIAL_K1     = 8'd4,
		REG_RADIAL_K2     = 8'd5,
		REG_TANGENTIAL_P1 = 8'd6,
		REG_TANGENTIAL_P2 = 8'd7
	} reg_idx_t;

	// Clamped Q4.20 value plus its clamp flag.
	typedef struct packed {
		logic                  s;
		logic signed [QW-1:0]  v;
	} qv_t;

	// Point carried through an iteration: target, current estimate, flag.
	typedef struct packed {
		logic signed [QW-1:0] mx;
		logic signed [QW-1:0] my;
		logic signed [QW-1:0] x;
		logic signed [QW-1:0] y;
		logic                 sat;
	} pt_t;

	// Distortion coefficients handed to every iteration.
	typedef struct packed {
		logic signed [QW-1:0] k1;
		logic signed [QW-1:0] k2;
		logic signed [QW-1:0] p1;
		logic signed [QW-1:0] p2;
	} coef_t;

	// Saturate a wide signed value to the Q4.20 range.
	function automatic qv_t sat_q(input logic signed [39:0] a);
		qv_t r;
		if (a > 40'sd8388607) begin
			r.s = 1'b1;
			r.v = 24'sh7fffff;
		end else if (a < -40'sd8388608) begin
			r.s = 1'b1;
			r.v = 24'sh800000;
		end else begin
			r.s = 1'b0;
			r.v = a[QW-1:0];
		end
		return r;
	endfunction

	// Q4.20 product, rounded half up, then saturated.
	function automatic qv_t qmul(input logic signed [QW-1:0] a, input logic signed [QW-1:0] b);
		logic signed [47:0] p;
		logic signed [48:0] pr;
		p  = a * b;
		pr = 49'(p) + 49'sd524288;
		return sat_q(40'(pr >>> 20));
	endfunction
endpackage

>>> rtl/core/puiu_if.sv
// Channel interfaces: pixel input, ray output and configuration write.
`timescale 1ns / 1ps
interface puiu_pix_if import puiu_pkg::*; ();
	logic            valid;
	logic            ready;
	logic [PIXW-1:0] pixel_x;
	logic [PIXW-1:0] pixel_y;
	modport source (output valid, pixel_x, pixel_y, input ready);
	modport sink   (input valid, pixel_x, pixel_y, output ready);
endinterface

interface puiu_ray_if import puiu_pkg::*; ();
	logic                 valid;
	logic                 ready;
	logic signed [QW-1:0] ray_x;
	logic signed [QW-1:0] ray_y;
	logic                 saturated;
	modport source (output valid, ray_x, ray_y, saturated, input ready);
	modport sink   (input valid, ray_x, ray_y, saturated, output ready);
endinterface

interface puiu_cfg_if import puiu_pkg::*; ();
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;
	modport source (output valid, index, data, input ready);
	modport sink   (input valid, index, data, output ready);
endinterface

>>> rtl/core/puiu_iter.sv
// One undistortion iteration u = m - D(u) as an eight-stage pipeline.
`timescale 1ns / 1ps
module puiu_iter import puiu_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  en,
	input  coef_t coef,
	input  logic  vin,
	input  pt_t   pin,
	output logic  vout,
	output pt_t   pout
);
	logic [8:1] v_q;
	pt_t b_s1, b_s2, b_s3, b_s4, b_s5, b_s6, b_s7;
	logic signed [QW-1:0] x2_s1, y2_s1, xy_s1;
	logic signed [QW-1:0] r2_s2, x2_s2, y2_s2, p1xy_s2, p2xy_s2;
	logic signed [QW-1:0] r4_s3, k1r2_s3, tx_s3, ty_s3, p1xy_s3, p2xy_s3;
	logic signed [QW-1:0] k2r4_s4, k1r2_s4, ptx_s4, pty_s4, p1xy_s4, p2xy_s4;
	logic signed [QW-1:0] rad_s5, ptx_s5, pty_s5, p1xy_s5, p2xy_s5;
	logic signed [QW-1:0] xr_s6, yr_s6, ptx_s6, pty_s6, p1xy_s6, p2xy_s6;
	logic signed [QW-1:0] dx_s7, dy_s7;
	qv_t q_x2, q_y2, q_xy, q_r2, q_p1xy, q_p2xy, q_r4, q_k1r2, q_tx, q_ty;
	qv_t q_k2r4, q_ptx, q_pty, q_rad, q_xr, q_yr, q_dx, q_dy, q_ux, q_uy;

	// Per-stage arithmetic
	always_comb begin
		q_x2   = qmul(pin.x, pin.x);
		q_y2   = qmul(pin.y, pin.y);
		q_xy   = qmul(pin.x, pin.y);
		q_r2   = sat_q(40'(x2_s1) + 40'(y2_s1));
		q_p1xy = qmul(coef.p1, xy_s1);
		q_p2xy = qmul(coef.p2, xy_s1);
		q_r4   = qmul(r2_s2, r2_s2);
		q_k1r2 = qmul(coef.k1, r2_s2);
		q_tx   = sat_q(40'(r2_s2) + 40'(x2_s2) * 40'sd2);
		q_ty   = sat_q(40'(r2_s2) + 40'(y2_s2) * 40'sd2);
		q_k2r4 = qmul(coef.k2, r4_s3);
		q_ptx  = qmul(coef.p2, tx_s3);
		q_pty  = qmul(coef.p1, ty_s3);
		q_rad  = sat_q(40'(k1r2_s4) + 40'(k2r4_s4));
		q_xr   = qmul(b_s5.x, rad_s5);
		q_yr   = qmul(b_s5.y, rad_s5);
		q_dx   = sat_q(40'(xr_s6) + 40'(p1xy_s6) * 40'sd2 + 40'(ptx_s6));
		q_dy   = sat_q(40'(yr_s6) + 40'(p2xy_s6) * 40'sd2 + 40'(pty_s6));
		q_ux   = sat_q(40'(b_s7.mx) - 40'(dx_s7));
		q_uy   = sat_q(40'(b_s7.my) - 40'(dy_s7));
	end

	// Valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= '0;
		end else if (en) begin
			v_q <= {v_q[7:1], vin};
		end
	end

	// Payload registers
	always_ff @(posedge clk) begin
		if (en) begin
			b_s1     <= {pin.mx, pin.my, pin.x, pin.y,
				pin.sat | q_x2.s | q_y2.s | q_xy.s};
			x2_s1    <= q_x2.v;
			y2_s1    <= q_y2.v;
			xy_s1    <= q_xy.v;

			b_s2     <= {b_s1.mx, b_s1.my, b_s1.x, b_s1.y,
				b_s1.sat | q_r2.s | q_p1xy.s | q_p2xy.s};
			r2_s2    <= q_r2.v;
			x2_s2    <= x2_s1;
			y2_s2    <= y2_s1;
			p1xy_s2  <= q_p1xy.v;
			p2xy_s2  <= q_p2xy.v;

			b_s3     <= {b_s2.mx, b_s2.my, b_s2.x, b_s2.y,
				b_s2.sat | q_r4.s | q_k1r2.s | q_tx.s | q_ty.s};
			r4_s3    <= q_r4.v;
			k1r2_s3  <= q_k1r2.v;
			tx_s3    <= q_tx.v;
			ty_s3    <= q_ty.v;
			p1xy_s3  <= p1xy_s2;
			p2xy_s3  <= p2xy_s2;

			b_s4     <= {b_s3.mx, b_s3.my, b_s3.x, b_s3.y,
				b_s3.sat | q_k2r4.s | q_ptx.s | q_pty.s};
			k2r4_s4  <= q_k2r4.v;
			k1r2_s4  <= k1r2_s3;
			ptx_s4   <= q_ptx.v;
			pty_s4   <= q_pty.v;
			p1xy_s4  <= p1xy_s3;
			p2xy_s4  <= p2xy_s3;

			b_s5     <= {b_s4.mx, b_s4.my, b_s4.x, b_s4.y, b_s4.sat | q_rad.s};
			rad_s5   <= q_rad.v;
			ptx_s5   <= ptx_s4;
			pty_s5   <= pty_s4;
			p1xy_s5  <= p1xy_s4;
			p2xy_s5  <= p2xy_s4;

			b_s6     <= {b_s5.mx, b_s5.my, b_s5.x, b_s5.y,
				b_s5.sat | q_xr.s | q_yr.s};
			xr_s6    <= q_xr.v;
			yr_s6    <= q_yr.v;
			ptx_s6   <= ptx_s5;
			pty_s6   <= pty_s5;
			p1xy_s6  <= p1xy_s5;
			p2xy_s6  <= p2xy_s5;

			b_s7     <= {b_s6.mx, b_s6.my, b_s6.x, b_s6.y,
				b_s6.sat | q_dx.s | q_dy.s};
			dx_s7    <= q_dx.v;
			dy_s7    <= q_dy.v;

			pout.mx  <= b_s7.mx;
			pout.my  <= b_s7.my;
			pout.x   <= q_ux.v;
			pout.y   <= q_uy.v;
			pout.sat <= b_s7.sat | q_ux.s | q_uy.s;
		end
	end

	assign vout = v_q[8];
endmodule

>>> rtl/core/pinhole_iterative_undistort.sv
// Top level: pinhole back-projection with pipelined iterative undistortion.
//
// Channels: pix (sink) takes pixel_x/pixel_y in unsigned 12.4; ray (source)
// gives ray_x/ray_y in signed Q4.20 and a saturated flag; cfg (sink) writes
// register index/data and is always ready. Indexes above 7 are dropped.
// The user must write configuration only while no point is in flight; the
// block itself does not enforce this. Throughput: one point per cycle while
// the output buffer has a free slot. Path from the pix transfer to the ray:
// two normalization stages, eight iterations of eight stages each, and the
// two-entry output buffer.
// Stall: the pipeline advances as a whole while the output buffer has a free
// slot, so one more point is taken while a finished ray waits; when both
// slots are full pix.ready drops and nothing in flight is lost.
// Reset clears the configuration registers to zero and empties the pipeline.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module pinhole_iterative_undistort import puiu_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	puiu_pix_if.sink   pix,
	puiu_ray_if.source ray,
	puiu_cfg_if.sink   cfg
);
	logic [PIXW-1:0] cx_q, cy_q;
	logic [IFW-1:0]  ifx_q, ify_q;
	coef_t           coef_q;
	logic            adv;
	logic [1:0]      v_n_q;
	logic signed [41:0] px_s1, py_s1;
	qv_t             q_mx, q_my;
	logic            v_it [ITERATIONS+1];
	pt_t             p_it [ITERATIONS+1];
	logic [1:0]      cnt_q;
	logic            wp_q, rp_q;
	pt_t             fifo_q [2];
	logic            push, pop;

	// Configuration registers
	assign cfg.ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cx_q   <= '0;
			cy_q   <= '0;
			ifx_q  <= '0;
			ify_q  <= '0;
			coef_q <= '0;
		end else if (cfg.valid) begin
			case (cfg.index)
				REG_CENTER_X:      cx_q      <= cfg.data[PIXW-1:0];
				REG_CENTER_Y:      cy_q      <= cfg.data[PIXW-1:0];
				REG_INV_FOCAL_X:   ifx_q     <= cfg.data;
				REG_INV_FOCAL_Y:   ify_q     <= cfg.data;
				REG_RADIAL_K1:     coef_q.k1 <= cfg.data;
				REG_RADIAL_K2:     coef_q.k2 <= cfg.data;
				REG_TANGENTIAL_P1: coef_q.p1 <= cfg.data;
				REG_TANGENTIAL_P2: coef_q.p2 <= cfg.data;
				default: ;
			endcase
		end
	end

	// Whole-pipeline advance while the output buffer has room
	assign adv       = (cnt_q != 2'd2);
	assign pix.ready = adv;

	// Normalization: (pixel - center) * inv_focal, then round to Q4.20
	always_comb begin
		q_mx = sat_q(40'((43'(px_s1) + 43'sd128) >>> 8));
		q_my = sat_q(40'((43'(py_s1) + 43'sd128) >>> 8));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_n_q <= '0;
		end else if (adv) begin
			v_n_q <= {v_n_q[0], pix.valid};
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			px_s1 <= 42'($signed({1'b0, pix.pixel_x}) - $signed({1'b0, cx_q}))
				* 42'($signed({1'b0, ifx_q}));
			py_s1 <= 42'($signed({1'b0, pix.pixel_y}) - $signed({1'b0, cy_q}))
				* 42'($signed({1'b0, ify_q}));
			p_it[0].mx  <= q_mx.v;
			p_it[0].my  <= q_my.v;
			p_it[0].x   <= q_mx.v;
			p_it[0].y   <= q_my.v;
			p_it[0].sat <= q_mx.s | q_my.s;
		end
	end
	assign v_it[0] = v_n_q[1];

	// Iteration chain
	for (genvar i = 0; i < ITERATIONS; i++) begin : g_iter
		puiu_iter u_iter (
			.clk   (clk),
			.arst_n(arst_n),
			.en    (adv),
			.coef  (coef_q),
			.vin   (v_it[i]),
			.pin   (p_it[i]),
			.vout  (v_it[i+1]),
			.pout  (p_it[i+1])
		);
	end

	// Two-entry output buffer
	assign push = adv && v_it[ITERATIONS];
	assign pop  = ray.valid && ray.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
		end else begin
			if (push) wp_q <= ~wp_q;
			if (pop)  rp_q <= ~rp_q;
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			fifo_q[wp_q] <= p_it[ITERATIONS];
		end
	end

	assign ray.valid     = (cnt_q != 2'd0);
	assign ray.ray_x     = fifo_q[rp_q].x;
	assign ray.ray_y     = fifo_q[rp_q].y;
	assign ray.saturated = fifo_q[rp_q].sat;

	`PUIU_ASSERT(a_cnt_range, cnt_q != 2'd3, "output buffer count out of range")
	`PUIU_ASSERT(a_cnt_ptr, (cnt_q == 2'd1) == (wp_q != rp_q), "buffer pointers disagree with count")
	`PUIU_ASSERT(a_held, ray.valid && !ray.ready |=> ray.valid && $stable(cnt_q != 2'd0), "waiting ray dropped")
	`PUIU_ASSERT(a_full_stall, cnt_q == 2'd2 |-> !push, "push into full output buffer")
endmodule
